[sv/prcrle_pkg.sv]
// ----------------------------------------------------------------------------
// prcrle_pkg
// Shared types, codes and tables for the data-segment RLE decoder.
// ----------------------------------------------------------------------------
package prcrle_pkg;

  localparam int ADDR_BITS_DEF = 16;
  localparam int UPC_W         = 4;
  localparam int CNT_W         = 7;

  // register index (byte address / 4)
  localparam logic REG_OUTPUT_BASE = 1'b0;

  // opcodes and opcode class bounds
  localparam logic [7:0] OP_END           = 8'h00;
  localparam logic [7:0] OP_TMPL_A        = 8'h01;
  localparam logic [7:0] OP_TMPL_B        = 8'h02;
  localparam logic [7:0] OP_TMPL_C        = 8'h03;
  localparam logic [7:0] OP_TMPL_D        = 8'h04;
  localparam logic [7:0] OP_INVALID_FIRST = 8'h05;
  localparam logic [7:0] OP_INVALID_LAST  = 8'h0F;
  localparam logic [7:0] OP_FF_RUN        = 8'h10;
  localparam logic [7:0] OP_FF_RUN_LAST   = 8'h1F;
  localparam logic [7:0] OP_REPEAT        = 8'h20;
  localparam logic [7:0] OP_REPEAT_LAST   = 8'h3F;
  localparam logic [7:0] OP_ZERO_RUN      = 8'h40;
  localparam logic [7:0] OP_ZERO_RUN_LAST = 8'h7F;
  localparam logic [7:0] OP_LITERAL       = 8'h80;

  // decode modes
  localparam logic [1:0] MODE_OPC  = 2'd0;
  localparam logic [1:0] MODE_TMPL = 2'd1;
  localparam logic [1:0] MODE_LIT  = 2'd2;
  localparam logic [1:0] MODE_REP  = 2'd3;

  // result status codes
  localparam logic [1:0] ST_NORMAL  = 2'd0;
  localparam logic [1:0] ST_END     = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_EARLY   = 2'd3;

  // microprogram entry points
  localparam logic [UPC_W-1:0] U_END   = 4'd0;
  localparam logic [UPC_W-1:0] U_INV   = 4'd1;
  localparam logic [UPC_W-1:0] U_ZRUN  = 4'd2;
  localparam logic [UPC_W-1:0] U_FRUN  = 4'd3;
  localparam logic [UPC_W-1:0] U_REP   = 4'd4;
  localparam logic [UPC_W-1:0] U_LITOP = 4'd5;
  localparam logic [UPC_W-1:0] U_REPOP = 4'd6;
  localparam logic [UPC_W-1:0] U_LITB  = 4'd7;
  localparam logic [UPC_W-1:0] U_TOP   = 4'd8;
  localparam logic [UPC_W-1:0] U_TOPD  = 4'd9;
  localparam logic [UPC_W-1:0] U_TCON  = 4'd10;
  localparam logic [UPC_W-1:0] U_EOI   = 4'd11;

  // template slots: bit 8 marks an operand slot
  localparam logic [8:0] OPD = 9'h100;
  localparam logic [8:0] TMPL_ROM [0:3][0:7] = '{
    '{9'h000, 9'h000, 9'h000, 9'h000, 9'h0FF, 9'h0FF, OPD,    OPD   },
    '{9'h000, 9'h000, 9'h000, 9'h000, 9'h0FF, OPD,    OPD,    OPD   },
    '{9'h0A9, 9'h0F0, 9'h000, 9'h000, OPD,    OPD,    9'h000, OPD   },
    '{9'h0A9, 9'h0F0, 9'h000, OPD,    OPD,    OPD,    9'h000, OPD   }
  };
  localparam logic [7:0] TMPL_OPS [0:3] = '{8'd2, 8'd3, 8'd3, 8'd4};

  typedef enum logic [1:0] {DSEL_ZERO, DSEL_ONES, DSEL_INB, DSEL_TCON} dsel_e;
  typedef enum logic [1:0] {RPT_NONE, RPT_CNT, RPT_TMPL} rpt_e;
  typedef enum logic [1:0] {SEQ_END, SEQ_GOTO, SEQ_EOI, SEQ_TMPL} seq_e;
  typedef enum logic [1:0] {STEP_KEEP, STEP_CLR, STEP_INC} step_op_e;
  typedef enum logic [1:0] {OPS_KEEP, OPS_TMPL, OPS_LIT, OPS_DEC} ops_op_e;

  typedef struct packed {
    logic             emit;
    dsel_e            dsel;
    logic             valid;
    logic [1:0]       stat;
    rpt_e             rpt;
    seq_e             seq;
    logic [UPC_W-1:0] nxt;
    logic             mode_ld;
    logic [1:0]       mode_val;
    step_op_e         step_op;
    ops_op_e          ops_op;
    logic             set_fin;
  } cword_t;

  typedef struct packed {
    logic   load;
    logic   exec;
    logic   done;
    cword_t cw;
  } ctl_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       fin;
    logic       eoi;
    logic       cnt_one;
    logic       tmpl_last;
    logic       can_emit;
  } dstat_t;

endpackage

[sv/prcrle_urom.sv]
// ----------------------------------------------------------------------------
// prcrle_urom
// Control store: one control word per microprogram step.
// ----------------------------------------------------------------------------
module prcrle_urom (
  input  logic [prcrle_pkg::UPC_W-1:0] upc_i,
  output prcrle_pkg::cword_t           cw_o
);

  always_comb begin
    cw_o          = '0;
    cw_o.dsel     = prcrle_pkg::DSEL_ZERO;
    cw_o.rpt      = prcrle_pkg::RPT_NONE;
    cw_o.seq      = prcrle_pkg::SEQ_END;
    cw_o.step_op  = prcrle_pkg::STEP_KEEP;
    cw_o.ops_op   = prcrle_pkg::OPS_KEEP;
    cw_o.stat     = prcrle_pkg::ST_NORMAL;
    cw_o.mode_val = prcrle_pkg::MODE_OPC;
    unique case (upc_i)
      prcrle_pkg::U_END: begin
        cw_o.emit    = 1'b1;
        cw_o.stat    = prcrle_pkg::ST_END;
        cw_o.set_fin = 1'b1;
      end
      prcrle_pkg::U_INV: begin
        cw_o.emit    = 1'b1;
        cw_o.stat    = prcrle_pkg::ST_INVALID;
        cw_o.set_fin = 1'b1;
      end
      prcrle_pkg::U_ZRUN: begin
        cw_o.emit  = 1'b1;
        cw_o.valid = 1'b1;
        cw_o.rpt   = prcrle_pkg::RPT_CNT;
      end
      prcrle_pkg::U_FRUN: begin
        cw_o.emit  = 1'b1;
        cw_o.valid = 1'b1;
        cw_o.dsel  = prcrle_pkg::DSEL_ONES;
        cw_o.rpt   = prcrle_pkg::RPT_CNT;
      end
      prcrle_pkg::U_REP: begin
        cw_o.emit     = 1'b1;
        cw_o.valid    = 1'b1;
        cw_o.dsel     = prcrle_pkg::DSEL_INB;
        cw_o.rpt      = prcrle_pkg::RPT_CNT;
        cw_o.mode_ld  = 1'b1;
        cw_o.mode_val = prcrle_pkg::MODE_OPC;
      end
      prcrle_pkg::U_LITOP: begin
        cw_o.mode_ld  = 1'b1;
        cw_o.mode_val = prcrle_pkg::MODE_LIT;
        cw_o.ops_op   = prcrle_pkg::OPS_LIT;
        cw_o.seq      = prcrle_pkg::SEQ_EOI;
      end
      prcrle_pkg::U_REPOP: begin
        cw_o.mode_ld  = 1'b1;
        cw_o.mode_val = prcrle_pkg::MODE_REP;
        cw_o.seq      = prcrle_pkg::SEQ_EOI;
      end
      prcrle_pkg::U_LITB: begin
        cw_o.emit   = 1'b1;
        cw_o.valid  = 1'b1;
        cw_o.dsel   = prcrle_pkg::DSEL_INB;
        cw_o.ops_op = prcrle_pkg::OPS_DEC;
      end
      prcrle_pkg::U_TOP: begin
        cw_o.mode_ld  = 1'b1;
        cw_o.mode_val = prcrle_pkg::MODE_TMPL;
        cw_o.step_op  = prcrle_pkg::STEP_CLR;
        cw_o.ops_op   = prcrle_pkg::OPS_TMPL;
        cw_o.seq      = prcrle_pkg::SEQ_GOTO;
        cw_o.nxt      = prcrle_pkg::U_TCON;
      end
      prcrle_pkg::U_TOPD: begin
        cw_o.emit    = 1'b1;
        cw_o.valid   = 1'b1;
        cw_o.dsel    = prcrle_pkg::DSEL_INB;
        cw_o.step_op = prcrle_pkg::STEP_INC;
        cw_o.ops_op  = prcrle_pkg::OPS_DEC;
        cw_o.seq     = prcrle_pkg::SEQ_TMPL;
        cw_o.nxt     = prcrle_pkg::U_TCON;
      end
      prcrle_pkg::U_TCON: begin
        cw_o.emit    = 1'b1;
        cw_o.valid   = 1'b1;
        cw_o.dsel    = prcrle_pkg::DSEL_TCON;
        cw_o.step_op = prcrle_pkg::STEP_INC;
        cw_o.rpt     = prcrle_pkg::RPT_TMPL;
      end
      prcrle_pkg::U_EOI: begin
        cw_o.emit = 1'b1;
      end
      default: begin
        cw_o.seq = prcrle_pkg::SEQ_END;
      end
    endcase
  end

endmodule

[sv/prcrle_seq.sv]
// ----------------------------------------------------------------------------
// prcrle_seq
// Step counter, opcode dispatch and jump logic of the microsequencer.
// ----------------------------------------------------------------------------
module prcrle_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         in_byte_i,
  input  prcrle_pkg::dstat_t dstat_i,
  output prcrle_pkg::ctl_t   ctl_o
);

  logic                         busy_q, busy_d;
  logic [prcrle_pkg::UPC_W-1:0] upc_q, upc_d, entry;
  prcrle_pkg::cword_t           cw;
  logic                         acc, fire, hold, done;

  prcrle_urom u_urom (
    .upc_i (upc_q),
    .cw_o  (cw)
  );

  always_comb begin
    unique case (dstat_i.mode)
      prcrle_pkg::MODE_TMPL: entry = prcrle_pkg::U_TOPD;
      prcrle_pkg::MODE_LIT:  entry = prcrle_pkg::U_LITB;
      prcrle_pkg::MODE_REP:  entry = prcrle_pkg::U_REP;
      default: begin
        priority if (in_byte_i == prcrle_pkg::OP_END)   entry = prcrle_pkg::U_END;
        else if (in_byte_i <= prcrle_pkg::OP_TMPL_D)    entry = prcrle_pkg::U_TOP;
        else if (in_byte_i < prcrle_pkg::OP_FF_RUN)     entry = prcrle_pkg::U_INV;
        else if (in_byte_i >= prcrle_pkg::OP_LITERAL)   entry = prcrle_pkg::U_LITOP;
        else if (in_byte_i >= prcrle_pkg::OP_ZERO_RUN)  entry = prcrle_pkg::U_ZRUN;
        else if (in_byte_i >= prcrle_pkg::OP_REPEAT)    entry = prcrle_pkg::U_REPOP;
        else                                            entry = prcrle_pkg::U_FRUN;
      end
    endcase
  end

  assign acc  = in_valid_i && !busy_q;
  assign fire = busy_q && (!cw.emit || dstat_i.can_emit);
  assign hold = ((cw.rpt == prcrle_pkg::RPT_CNT) && !dstat_i.cnt_one) ||
                ((cw.rpt == prcrle_pkg::RPT_TMPL) && !dstat_i.tmpl_last);

  always_comb begin
    busy_d = busy_q;
    upc_d  = upc_q;
    done   = 1'b0;
    if (acc) begin
      if (!dstat_i.fin) begin
        busy_d = 1'b1;
        upc_d  = entry;
      end
    end else if (fire && !hold) begin
      unique case (cw.seq)
        prcrle_pkg::SEQ_END:  done = 1'b1;
        prcrle_pkg::SEQ_GOTO: upc_d = cw.nxt;
        prcrle_pkg::SEQ_EOI: begin
          if (dstat_i.eoi) upc_d = prcrle_pkg::U_EOI;
          else done = 1'b1;
        end
        prcrle_pkg::SEQ_TMPL: begin
          if (dstat_i.tmpl_last) done = 1'b1;
          else upc_d = cw.nxt;
        end
      endcase
      if (done) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      upc_q  <= prcrle_pkg::U_END;
    end else begin
      busy_q <= busy_d;
      upc_q  <= upc_d;
    end
  end

  assign in_ready_o = !busy_q;
  assign ctl_o.load = acc && !dstat_i.fin;
  assign ctl_o.exec = fire;
  assign ctl_o.done = done;
  assign ctl_o.cw   = cw;

  a_fin_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && dstat_i.fin |=> !busy_q)
    else $error("item started after end of stream");

  a_upc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> upc_q <= prcrle_pkg::U_EOI)
    else $error("step counter out of program");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> !busy_q)
    else $error("sequencer still busy after program end");

endmodule

[sv/prcrle_dp.sv]
// ----------------------------------------------------------------------------
// prcrle_dp
// Decoder state, address counter, config register and result register.
// ----------------------------------------------------------------------------
module prcrle_dp #(
  parameter int ADDR_BITS = prcrle_pkg::ADDR_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  prcrle_pkg::ctl_t   ctl_i,
  output prcrle_pkg::dstat_t dstat_o,
  input  logic [7:0]         in_byte_i,
  input  logic               end_of_input_i,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic [15:0]        out_addr_o,
  output logic               byte_valid_o,
  output logic               last_o,
  output logic [1:0]         status_o
);

  logic [1:0]                   mode_q, mode_d;
  logic [7:0]                   held_q, ops_q, ops_d, byte_q;
  logic [3:0]                   step_q, step_d, nstep;
  logic [prcrle_pkg::CNT_W-1:0] cnt_q, cnt_d, cnt_init;
  logic [ADDR_BITS-1:0]         waddr_q, waddr_d;
  logic [15:0]                  base_q;
  logic                         fin_q, fin_d, eoi_q, oval_q, oval_d;
  logic [1:0]                   tix;
  logic [8:0]                   cur_slot, nxt_slot;
  logic                         cfg_wr, emit_en;
  logic [7:0]                   obyte;
  logic [1:0]                   ostat;

  prcrle_pkg::cword_t cw;
  assign cw = ctl_i.cw;

  assign cfg_wr   = psel && penable && pwrite &&
                    (paddr[2] == prcrle_pkg::REG_OUTPUT_BASE);
  assign prdata   = 32'(base_q);
  assign tix      = held_q[1:0] - 2'd1;
  assign nstep    = step_q + 4'd1;
  assign cur_slot = prcrle_pkg::TMPL_ROM[tix][step_q[2:0]];
  assign nxt_slot = prcrle_pkg::TMPL_ROM[tix][nstep[2:0]];
  assign emit_en  = ctl_i.exec && cw.emit;

  always_comb begin
    if (mode_q == prcrle_pkg::MODE_REP) begin
      cnt_init = prcrle_pkg::CNT_W'(held_q[4:0]) + prcrle_pkg::CNT_W'(2);
    end else if (in_byte_i[6]) begin
      cnt_init = prcrle_pkg::CNT_W'(in_byte_i[5:0]) + prcrle_pkg::CNT_W'(1);
    end else begin
      cnt_init = prcrle_pkg::CNT_W'(in_byte_i[3:0]) + prcrle_pkg::CNT_W'(1);
    end
  end

  always_comb begin
    unique case (cw.dsel)
      prcrle_pkg::DSEL_ZERO: obyte = 8'h00;
      prcrle_pkg::DSEL_ONES: obyte = 8'hFF;
      prcrle_pkg::DSEL_INB:  obyte = byte_q;
      prcrle_pkg::DSEL_TCON: obyte = cur_slot[7:0];
    endcase
    ostat = (ctl_i.done && eoi_q && (cw.stat == prcrle_pkg::ST_NORMAL)) ?
            prcrle_pkg::ST_EARLY : cw.stat;
  end

  always_comb begin
    mode_d  = mode_q;
    ops_d   = ops_q;
    step_d  = step_q;
    cnt_d   = cnt_q;
    fin_d   = fin_q;
    waddr_d = waddr_q;
    oval_d  = oval_q && !out_ready_i;
    if (cfg_wr) begin
      waddr_d = ADDR_BITS'(pwdata[15:0]);
    end
    if (ctl_i.load) begin
      cnt_d = cnt_init;
    end
    if (ctl_i.exec) begin
      if (cw.mode_ld) mode_d = cw.mode_val;
      unique case (cw.step_op)
        prcrle_pkg::STEP_CLR: step_d = 4'd0;
        prcrle_pkg::STEP_INC: begin
          step_d = nstep;
          if (nstep[3]) mode_d = prcrle_pkg::MODE_OPC;
        end
        default: step_d = step_q;
      endcase
      unique case (cw.ops_op)
        prcrle_pkg::OPS_TMPL: ops_d = prcrle_pkg::TMPL_OPS[held_q[1:0] - 2'd1];
        prcrle_pkg::OPS_LIT:  ops_d = {1'b0, byte_q[6:0]} + 8'd1;
        prcrle_pkg::OPS_DEC: begin
          if (ops_q != 8'd0) ops_d = ops_q - 8'd1;
          if (mode_q == prcrle_pkg::MODE_LIT && ops_q <= 8'd1) begin
            mode_d = prcrle_pkg::MODE_OPC;
          end
        end
        default: ops_d = ops_q;
      endcase
      if (cw.rpt == prcrle_pkg::RPT_CNT) cnt_d = cnt_q - prcrle_pkg::CNT_W'(1);
      if (cw.set_fin) fin_d = 1'b1;
      if (ctl_i.done && eoi_q) begin
        fin_d  = 1'b1;
        mode_d = prcrle_pkg::MODE_OPC;
      end
      if (cw.emit) begin
        oval_d = 1'b1;
        if (cw.valid) waddr_d = waddr_q + ADDR_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= prcrle_pkg::MODE_OPC;
      held_q  <= 8'h00;
      ops_q   <= 8'h00;
      step_q  <= 4'd0;
      cnt_q   <= '0;
      fin_q   <= 1'b0;
      waddr_q <= '0;
      base_q  <= 16'h0000;
      oval_q  <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      ops_q   <= ops_d;
      step_q  <= step_d;
      cnt_q   <= cnt_d;
      fin_q   <= fin_d;
      waddr_q <= waddr_d;
      oval_q  <= oval_d;
      if (cfg_wr) base_q <= pwdata[15:0];
      if (ctl_i.load && mode_q == prcrle_pkg::MODE_OPC) held_q <= in_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      byte_q <= in_byte_i;
      eoi_q  <= end_of_input_i;
    end
    if (emit_en) begin
      out_byte_o   <= obyte;
      out_addr_o   <= 16'(waddr_q);
      byte_valid_o <= cw.valid;
      last_o       <= ctl_i.done;
      status_o     <= ostat;
    end
  end

  assign out_valid_o       = oval_q;
  assign dstat_o.mode      = mode_q;
  assign dstat_o.fin       = fin_q;
  assign dstat_o.eoi       = eoi_q;
  assign dstat_o.cnt_one   = (cnt_q == prcrle_pkg::CNT_W'(1));
  assign dstat_o.tmpl_last = nstep[3] || nxt_slot[8];
  assign dstat_o.can_emit  = !oval_q || out_ready_i;

  a_cnt_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.exec && cw.rpt == prcrle_pkg::RPT_CNT |-> cnt_q != '0)
    else $error("run counter underflow");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= 4'd8)
    else $error("template step past end");

  a_fin_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |=> fin_q)
    else $error("finished flag dropped");

endmodule

[sv/prc_data_rle_decoder.sv]
// ----------------------------------------------------------------------------
// prc_data_rle_decoder
// Run-length decoder for a compressed initialized-data segment.
// ----------------------------------------------------------------------------
//  channel  | signals                                         | dir
//  ---------+-------------------------------------------------+-----
//  in       | in_valid_i/in_ready_o, in_byte_i, end_of_input_i | in
//  out      | out_valid_o/out_ready_i, out_byte_o, out_addr_o, | out
//           | byte_valid_o, last_o, status_o                   |
//  cfg      | psel, penable, pwrite, paddr, pwdata, prdata,    | in
//           | pready (output_base at 0)                        |
//
//  An item is taken while idle; the microprogram then runs one step per
//  cycle unless a result stalls: one step per result, plus one for a
//  literal, repeat or template opcode. The single-step sequencer sets
//  the rate. Items after the end of stream are taken and dropped.
//  Reset clears the control state and output_base, not the data registers.
//  A stalled result holds the sequencer at its next emitting step.
// ----------------------------------------------------------------------------
module prc_data_rle_decoder #(
  parameter int ADDR_BITS = prcrle_pkg::ADDR_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        end_of_input_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic [15:0] out_addr_o,
  output logic        byte_valid_o,
  output logic        last_o,
  output logic [1:0]  status_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  prcrle_pkg::ctl_t   ctl;
  prcrle_pkg::dstat_t dstat;

  assign pready = 1'b1;

  prcrle_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .dstat_i    (dstat),
    .ctl_o      (ctl)
  );

  prcrle_dp #(
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .dstat_o        (dstat),
    .in_byte_i      (in_byte_i),
    .end_of_input_i (end_of_input_i),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .out_addr_o     (out_addr_o),
    .byte_valid_o   (byte_valid_o),
    .last_o         (last_o),
    .status_o       (status_o)
  );

endmodule

[sim/prc_data_rle_decoder_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// prc_data_rle_decoder_test
// Feeds compressed data-segment bytes through the decoder and checks every
// decompressed byte, address and status against a local decoder model,
// with random stalls on both channels and several output base settings.
// ----------------------------------------------------------------------------
module prc_data_rle_decoder_test;

  localparam int SETTLE_CYCLES = 16;

  // bit 8 marks a slot filled by an operand byte
  localparam logic [8:0] SLOT = 9'h100;
  localparam logic [8:0] TEMPLATE [4][8] = '{
    '{9'h000, 9'h000, 9'h000, 9'h000, 9'h0FF, 9'h0FF, SLOT,   SLOT  },
    '{9'h000, 9'h000, 9'h000, 9'h000, 9'h0FF, SLOT,   SLOT,   SLOT  },
    '{9'h0A9, 9'h0F0, 9'h000, 9'h000, SLOT,   SLOT,   9'h000, SLOT  },
    '{9'h0A9, 9'h0F0, 9'h000, SLOT,   SLOT,   SLOT,   9'h000, SLOT  }
  };

  typedef enum {END_MARKER, END_INVALID, END_EARLY_QUIET, END_EARLY_RUN,
                END_EARLY_TEMPLATE} stream_end_e;

  typedef struct packed {
    logic [7:0]  data;
    logic [15:0] addr;
    logic        bvalid;
    logic        last;
    logic [1:0]  status;
  } out_item_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_eoi;
  logic        out_ready;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [7:0]  out_byte_o;
  logic [15:0] out_addr_o;
  logic        byte_valid_o;
  logic        last_o;
  logic [1:0]  status_o;
  logic [31:0] prdata;
  logic        pready;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned mismatches;

  // decoder model state
  out_item_t   pending_out [$];
  logic [1:0]  dec_mode     = prcrle_pkg::MODE_OPC;
  logic [7:0]  held_op      = 8'h00;
  int unsigned lit_left     = 0;
  int unsigned tmpl_pos     = 0;
  logic [15:0] wr_addr      = 16'h0000;
  logic        stream_done  = 1'b0;

  prc_data_rle_decoder u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .in_byte_i      (in_byte),
    .end_of_input_i (in_eoi),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .out_byte_o     (out_byte_o),
    .out_addr_o     (out_addr_o),
    .byte_valid_o   (byte_valid_o),
    .last_o         (last_o),
    .status_o       (status_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("prc_data_rle_decoder: mismatch");
    $finish;
  end

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  function automatic void push_out(logic [7:0] data, logic bvalid, logic [1:0] st);
    out_item_t r;
    r.data   = data;
    r.addr   = wr_addr;
    r.bvalid = bvalid;
    r.last   = 1'b0;
    r.status = st;
    pending_out.insert(pending_out.size(), r);
    if (bvalid) wr_addr = wr_addr + 16'd1;
  endfunction

  // emit template constants up to the next operand slot
  function automatic void push_tmpl_consts();
    logic [1:0] row;
    row = held_op[1:0] - 2'd1;
    while (tmpl_pos < 8 && TEMPLATE[row][tmpl_pos] != SLOT) begin
      push_out(TEMPLATE[row][tmpl_pos][7:0], 1'b1, prcrle_pkg::ST_NORMAL);
      tmpl_pos++;
    end
    if (tmpl_pos >= 8) dec_mode = prcrle_pkg::MODE_OPC;
  endfunction

  function automatic void expand_byte(logic [7:0] b, logic eoi);
    int unsigned first;
    int unsigned k;
    int unsigned tail_ix;
    logic        early;
    out_item_t   tail;
    if (stream_done) return;
    first = pending_out.size();
    unique case (dec_mode)
      prcrle_pkg::MODE_TMPL: begin
        push_out(b, 1'b1, prcrle_pkg::ST_NORMAL);
        tmpl_pos++;
        push_tmpl_consts();
      end
      prcrle_pkg::MODE_LIT: begin
        push_out(b, 1'b1, prcrle_pkg::ST_NORMAL);
        if (lit_left > 0) lit_left--;
        if (lit_left == 0) dec_mode = prcrle_pkg::MODE_OPC;
      end
      prcrle_pkg::MODE_REP: begin
        for (k = 0; k < held_op[4:0] + 2; k++) push_out(b, 1'b1, prcrle_pkg::ST_NORMAL);
        dec_mode = prcrle_pkg::MODE_OPC;
      end
      default: begin
        held_op = b;
        if (b == prcrle_pkg::OP_END) begin
          push_out(8'h00, 1'b0, prcrle_pkg::ST_END);
          stream_done = 1'b1;
        end else if (b <= prcrle_pkg::OP_TMPL_D) begin
          tmpl_pos = 0;
          dec_mode = prcrle_pkg::MODE_TMPL;
          push_tmpl_consts();
        end else if (b < prcrle_pkg::OP_FF_RUN) begin
          push_out(8'h00, 1'b0, prcrle_pkg::ST_INVALID);
          stream_done = 1'b1;
        end else if (b >= prcrle_pkg::OP_LITERAL) begin
          lit_left = b - prcrle_pkg::OP_LITERAL + 1;
          dec_mode = prcrle_pkg::MODE_LIT;
        end else if (b >= prcrle_pkg::OP_ZERO_RUN) begin
          for (k = 0; k <= b - prcrle_pkg::OP_ZERO_RUN; k++)
            push_out(8'h00, 1'b1, prcrle_pkg::ST_NORMAL);
        end else if (b >= prcrle_pkg::OP_REPEAT) begin
          dec_mode = prcrle_pkg::MODE_REP;
        end else begin
          for (k = 0; k <= b - prcrle_pkg::OP_FF_RUN; k++)
            push_out(8'hFF, 1'b1, prcrle_pkg::ST_NORMAL);
        end
      end
    endcase
    early = eoi && !stream_done;
    if (early) begin
      if (pending_out.size() == first) push_out(8'h00, 1'b0, prcrle_pkg::ST_EARLY);
      stream_done = 1'b1;
      dec_mode = prcrle_pkg::MODE_OPC;
    end
    if (pending_out.size() > first) begin
      tail_ix = pending_out.size() - 1;
      tail = pending_out[tail_ix];
      tail.last = 1'b1;
      if (early) tail.status = prcrle_pkg::ST_EARLY;
      pending_out[tail_ix] = tail;
    end
  endfunction

  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin : check_results
    out_item_t got;
    out_item_t want;
    if (rst_ni) begin
      if (in_valid && in_ready_o) expand_byte(in_byte, in_eoi);
      if (out_valid_o && out_ready) begin
        got = {out_byte_o, out_addr_o, byte_valid_o, last_o, status_o};
        if (pending_out.size() == 0) begin
          report_mismatch($sformatf(
            "unexpected item: byte %02h addr %04h bv %0b last %0b st %0d",
            got.data, got.addr, got.bvalid, got.last, got.status));
        end else begin
          want = pending_out.pop_front();
          if (got !== want)
            report_mismatch($sformatf(
              "got byte %02h addr %04h bv %0b last %0b st %0d, want %02h %04h %0b %0b %0d",
              got.data, got.addr, got.bvalid, got.last, got.status,
              want.data, want.addr, want.bvalid, want.last, want.status));
        end
      end
    end
  end

  task automatic send_item(logic [7:0] b, logic eoi);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_eoi   <= eoi;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // stop sending and wait for every expected item; optionally let the block settle
  task automatic drain_results(logic settle);
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_out.size() != 0) @(posedge clk_i);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_base(logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {prcrle_pkg::REG_OUTPUT_BASE, 2'b00};
    pwdata  <= {16'h0000, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    wr_addr = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    psel <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[15:0] !== value)
      report_mismatch($sformatf("output_base read %04h, want %04h", prdata[15:0], value));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_command(output int unsigned count);
    logic [7:0]  seq [$];
    logic [7:0]  op;
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      op = 8'($urandom_range(prcrle_pkg::OP_TMPL_A, prcrle_pkg::OP_TMPL_D));
      len = (op == prcrle_pkg::OP_TMPL_A) ? 2 : (op == prcrle_pkg::OP_TMPL_D) ? 4 : 3;
      seq.insert(seq.size(), op);
      repeat (len) seq.insert(seq.size(), 8'($urandom_range(0, 255)));
    end else if (pick < 45) begin
      len = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 7);
      seq.insert(seq.size(), prcrle_pkg::OP_LITERAL | len[7:0]);
      repeat (len + 1) seq.insert(seq.size(), 8'($urandom_range(0, 255)));
    end else if (pick < 58) begin
      seq.insert(seq.size(), 8'($urandom_range(prcrle_pkg::OP_ZERO_RUN,
                                               prcrle_pkg::OP_ZERO_RUN_LAST)));
    end else if (pick < 71) begin
      seq.insert(seq.size(), 8'($urandom_range(prcrle_pkg::OP_REPEAT,
                                               prcrle_pkg::OP_REPEAT_LAST)));
      seq.insert(seq.size(), 8'($urandom_range(0, 255)));
    end else if (pick < 84) begin
      seq.insert(seq.size(), 8'($urandom_range(prcrle_pkg::OP_FF_RUN,
                                               prcrle_pkg::OP_FF_RUN_LAST)));
    end else begin
      // literal data that looks like end, template and invalid opcodes
      len = $urandom_range(0, 3);
      seq.insert(seq.size(), prcrle_pkg::OP_LITERAL | len[7:0]);
      repeat (len + 1)
        seq.insert(seq.size(), 8'($urandom_range(prcrle_pkg::OP_END,
                                                 prcrle_pkg::OP_INVALID_LAST)));
    end
    foreach (seq[i]) send_item(seq[i], 1'b0);
    count = seq.size();
  endtask

  task automatic test_directed_ops();
    logic [7:0] seq [$];
    write_base(16'hFFF8);
    seq = '{prcrle_pkg::OP_TMPL_A, 8'h00, 8'hFF,
            prcrle_pkg::OP_TMPL_B, 8'h5A, 8'hA5, 8'h0F,
            prcrle_pkg::OP_TMPL_C, 8'h80, 8'h7F, 8'h01,
            prcrle_pkg::OP_TMPL_D, 8'h00, 8'hFF, 8'h10, 8'hEE,
            prcrle_pkg::OP_LITERAL | 8'h01, 8'h00, prcrle_pkg::OP_INVALID_LAST,
            prcrle_pkg::OP_ZERO_RUN_LAST, prcrle_pkg::OP_ZERO_RUN,
            prcrle_pkg::OP_REPEAT_LAST, 8'hAA, prcrle_pkg::OP_REPEAT, 8'h55,
            prcrle_pkg::OP_FF_RUN_LAST, prcrle_pkg::OP_FF_RUN};
    foreach (seq[i]) send_item(seq[i], 1'b0);
  endtask

  task automatic test_random_stream(int unsigned n_items, logic [15:0] base);
    int unsigned sent;
    int unsigned count;
    drain_results(1'b1);
    write_base(base);
    sent = 0;
    while (sent < n_items) begin
      send_command(count);
      sent += count;
      if ($urandom_range(0, 39) == 0) drain_results(1'b0);
    end
  endtask

  task automatic test_stream_end();
    stream_end_e kind;
    kind = stream_end_e'($urandom_range(0, 4));
    unique case (kind)
      END_MARKER:  send_item(prcrle_pkg::OP_END, 1'($urandom_range(0, 1)));
      END_INVALID: send_item(8'($urandom_range(prcrle_pkg::OP_INVALID_FIRST,
                                               prcrle_pkg::OP_INVALID_LAST)),
                             1'($urandom_range(0, 1)));
      END_EARLY_QUIET: send_item(prcrle_pkg::OP_LITERAL | 8'($urandom_range(0, 127)), 1'b1);
      END_EARLY_RUN:   send_item(8'($urandom_range(prcrle_pkg::OP_ZERO_RUN,
                                                   prcrle_pkg::OP_ZERO_RUN_LAST)), 1'b1);
      default: begin
        send_item(prcrle_pkg::OP_TMPL_D, 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);
      end
    endcase
    // stream is closed: these are taken and dropped
    repeat (4) send_item(8'($urandom_range(0, 255)), 1'b1);
    drain_results(1'b1);
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid      = 1'b0;
    in_byte       = 8'h00;
    in_eoi        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = {prcrle_pkg::REG_OUTPUT_BASE, 2'b00};
    pwdata        = 32'h0;
    mismatches    = 0;
    send_idle_pct = 29;
    recv_idle_pct = 50;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_ops();
    test_random_stream(150, 16'hFFFF);
    send_idle_pct = 50;
    recv_idle_pct = 29;
    test_random_stream(150, 16'h0000);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_stream(150, 16'($urandom_range(0, 65535)));
    test_stream_end();

    if (mismatches == 0) begin
      $display("prc_data_rle_decoder: match");
    end else begin
      $display("prc_data_rle_decoder: mismatch");
    end
    $finish;
  end

endmodule
